// File: hdl/afd_pkg.sv
// Package for the ATM frame discard admission block.
// Holds widths, operation codes, register indexes and the shared structs.
// Used by every other file of the block; depends on nothing.
`timescale 1ns / 1ps

package afd_pkg;

  // Field widths fixed by the cell format and the register map.
  localparam int unsigned OP_W        = 2;
  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned CHAN_SPAN   = 2 ** CHAN_W;
  localparam int unsigned CHAN_CMP_W  = 17;
  localparam int unsigned THR_W       = 11;
  localparam int unsigned QLEN_W      = 11;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 11;

  // Defaults for the top-level parameters.
  localparam int unsigned BUFFER_CELLS_DEF = 1024;
  localparam int unsigned CHANNELS_DEF     = 256;

  // Command queue between front and back; the depth must be a power of two.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes and reset values.
  localparam logic [CFG_INDEX_W-1:0] REG_EARLY_DISCARD = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_PRIORITY  = CFG_INDEX_W'(1);
  localparam logic [THR_W-1:0]       EDT_RESET         = THR_W'(600);
  localparam logic [THR_W-1:0]       LPT_RESET         = THR_W'(100);

  typedef enum logic [OP_W-1:0] {
    OP_AAL5   = 2'd0,
    OP_OTHER  = 2'd1,
    OP_DEPART = 2'd2,
    OP_STATS  = 2'd3
  } op_t;

  // Classified transaction handed from the front to the back.
  typedef struct packed {
    op_t               op;
    logic              bad_channel;
    logic [CHAN_W-1:0] channel;
    logic              clp;
    logic              eof;
    logic              red;
  } cmd_t;

  // One channel row of the state memory.
  typedef struct packed {
    logic             start;
    logic             accept;
    logic [CNT_W-1:0] rx;
    logic [CNT_W-1:0] rx_high;
    logic [CNT_W-1:0] lost;
    logic [CNT_W-1:0] lost_high;
    logic [CNT_W-1:0] served;
  } row_t;

  localparam row_t ROW_RESET = '{start: 1'b1, accept: 1'b0, rx: '0, rx_high: '0,
                                 lost: '0, lost_high: '0, served: '0};

  typedef struct packed {
    logic [THR_W-1:0] early_discard_threshold;
    logic [THR_W-1:0] low_priority_threshold;
  } cfg_t;

endpackage

// File: hdl/afd_in_if.sv
// Channel interface carrying arriving cell, departure and query transactions.
// Depends on afd_pkg for the field widths.
`timescale 1ns / 1ps

interface afd_in_if
  import afd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [CHAN_W-1:0] channel;
  logic              cell_loss_priority;
  logic              end_of_frame;
  logic              red_early_drop;

  modport source (output valid, operation, channel, cell_loss_priority, end_of_frame,
                  red_early_drop, input ready);
  modport sink (input valid, operation, channel, cell_loss_priority, end_of_frame,
                red_early_drop, output ready);
endinterface

// File: hdl/afd_out_if.sv
// Channel interface carrying one result transaction per input transaction.
// Depends on afd_pkg for the field widths.
`timescale 1ns / 1ps

interface afd_out_if
  import afd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              status;
  logic              accepted;
  logic [QLEN_W-1:0] queue_length;
  logic [CNT_W-1:0]  received_count;
  logic [CNT_W-1:0]  received_high_count;
  logic [CNT_W-1:0]  lost_count;
  logic [CNT_W-1:0]  lost_high_count;
  logic [CNT_W-1:0]  served_count;

  modport source (output valid, status, accepted, queue_length, received_count,
                  received_high_count, lost_count, lost_high_count, served_count,
                  input ready);
  modport sink (input valid, status, accepted, queue_length, received_count,
                received_high_count, lost_count, lost_high_count, served_count,
                output ready);
endinterface

// File: hdl/afd_front.sv
// Front stage: accepts input transactions and classifies them into commands.
// Depends on afd_pkg and afd_in_if.
`timescale 1ns / 1ps

module afd_front
  import afd_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  afd_in_if.sink   item,
  output logic     push_valid,
  output cmd_t     push_cmd,
  input  logic     push_ready
);

  localparam logic [CHAN_CMP_W-1:0] CHAN_LIMIT = CHAN_CMP_W'(CHANNELS);

  logic [CHAN_CMP_W-1:0] ch_wide;
  cmd_t                  cmd;

  // The stage register frees up whenever its command moves into the queue.
  assign item.ready = !push_valid || push_ready;

  // Decode the operation and check the channel against the table size.
  assign ch_wide = CHAN_CMP_W'(item.channel);
  always_comb begin
    cmd.op          = op_t'(item.operation);
    cmd.bad_channel = (ch_wide >= CHAN_LIMIT);
    cmd.channel     = item.channel;
    cmd.clp         = item.cell_loss_priority;
    cmd.eof         = item.end_of_frame;
    cmd.red         = item.red_early_drop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      push_valid <= 1'b0;
    end else if (item.ready) begin
      push_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      push_cmd <= cmd;
    end
  end

endmodule

// File: hdl/afd_queue.sv
// Short command queue that decouples the front from the back.
// Depends on afd_pkg for the command type and queue depth.
`timescale 1ns / 1ps

module afd_queue
  import afd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  cmd_t push_cmd,
  output logic push_ready,
  output logic pop_valid,
  output cmd_t pop_cmd,
  input  logic pop
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointers wrap naturally because the depth is a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: hdl/afd_back.sv
// Back stage: per-channel read-modify-write of flags and counters, buffer
// occupancy and the result register. Depends on afd_pkg and afd_out_if.
`timescale 1ns / 1ps

module afd_back
  import afd_pkg::*;
#(
  parameter int unsigned BUFFER_CELLS = BUFFER_CELLS_DEF,
  parameter int unsigned CHANNELS     = CHANNELS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     q_valid,
  input  cmd_t     q_cmd,
  output logic     q_pop,
  afd_out_if.source res
);

  localparam int unsigned ROWS   = (CHANNELS < CHAN_SPAN) ? CHANNELS : CHAN_SPAN;
  localparam int unsigned ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned OCC_W  = $clog2(BUFFER_CELLS + 1);
  localparam int unsigned CMP_W  = (OCC_W > THR_W) ? OCC_W : THR_W;
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(BUFFER_CELLS);

  row_t              mem [ROWS];
  row_t              mem_q;
  logic [ROWS-1:0]   row_valid;
  logic              fwd_valid;
  logic [ROW_AW-1:0] fwd_idx;
  row_t              fwd_row;
  logic              s2_valid;
  cmd_t              s2_cmd;
  logic [OCC_W-1:0]  occupancy;
  logic [OCC_W-1:0]  occupancy_next;
  logic [ROW_AW-1:0] head_idx;
  logic [ROW_AW-1:0] s2_idx;
  logic              commit;
  logic              s2_free;
  row_t              row_cur;
  row_t              row_new;
  logic              row_write;
  logic              report;
  logic              status;
  logic              accepted;
  logic              keep;
  logic [CMP_W-1:0]  occ_ext;
  logic [CMP_W-1:0]  occ_next_ext;
  logic [CMP_W-1:0]  edt_ext;
  logic [CMP_W-1:0]  lpt_ext;

  // The second stage commits when the result register is free or draining.
  assign commit   = s2_valid && (!res.valid || res.ready);
  assign s2_free  = !s2_valid || commit;
  assign q_pop    = q_valid && s2_free;
  assign head_idx = q_cmd.channel[ROW_AW-1:0];
  assign s2_idx   = s2_cmd.channel[ROW_AW-1:0];

  // Current row: the write of the previous transaction is forwarded, since
  // the memory read for this one happened on the same edge as that write.
  always_comb begin
    if (fwd_valid && (fwd_idx == s2_idx)) begin
      row_cur = fwd_row;
    end else if (row_valid[s2_idx]) begin
      row_cur = mem_q;
    end else begin
      row_cur = ROW_RESET;
    end
  end

  assign occ_ext      = CMP_W'(occupancy);
  assign occ_next_ext = CMP_W'(occupancy_next);
  assign edt_ext      = CMP_W'(cfg.early_discard_threshold);
  assign lpt_ext      = CMP_W'(cfg.low_priority_threshold);

  // Admission decision and counter updates for the transaction in stage two.
  always_comb begin
    row_new        = row_cur;
    row_write      = 1'b0;
    report         = 1'b0;
    status         = 1'b0;
    accepted       = 1'b0;
    keep           = row_cur.accept;
    occupancy_next = occupancy;
    case (s2_cmd.op)
      OP_AAL5: begin
        if (s2_cmd.bad_channel) begin
          status = 1'b1;
        end else begin
          report     = 1'b1;
          row_write  = 1'b1;
          row_new.rx = row_cur.rx + 1'b1;
          if (!s2_cmd.clp) begin
            row_new.rx_high = row_cur.rx_high + 1'b1;
          end
          // The first cell of a frame decides whether the frame is taken.
          if (row_cur.start) begin
            row_new.start = 1'b0;
            keep          = (occ_ext < edt_ext) && !s2_cmd.red;
          end
          if (s2_cmd.eof) begin
            row_new.start = 1'b1;
          end
          if (s2_cmd.clp && (occ_ext > lpt_ext)) begin
            keep = 1'b0;
          end
          if (keep && (occupancy < OCC_FULL)) begin
            occupancy_next = occupancy + 1'b1;
            row_new.served = row_cur.served + 1'b1;
            accepted       = 1'b1;
          end else begin
            // A refused cell, including one that finds the buffer full.
            keep         = 1'b0;
            row_new.lost = row_cur.lost + 1'b1;
            if (!s2_cmd.clp) begin
              row_new.lost_high = row_cur.lost_high + 1'b1;
            end
          end
          row_new.accept = keep;
        end
      end
      OP_OTHER: begin
        if (occupancy < OCC_FULL) begin
          occupancy_next = occupancy + 1'b1;
          accepted       = 1'b1;
        end
      end
      OP_DEPART: begin
        if (occupancy != '0) begin
          occupancy_next = occupancy - 1'b1;
        end
      end
      OP_STATS: begin
        if (s2_cmd.bad_channel) begin
          status = 1'b1;
        end else begin
          report = 1'b1;
        end
      end
      default: begin
        status = 1'b0;
      end
    endcase
  end

  // Channel state memory: read at the queue head, written at commit.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      mem_q <= mem[head_idx];
    end
    if (commit && row_write) begin
      mem[s2_idx] <= row_new;
    end
  end

  // Row valid bits make untouched rows read as their reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      fwd_valid <= 1'b0;
    end else if (commit && row_write) begin
      row_valid[s2_idx] <= 1'b1;
      fwd_valid         <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && row_write) begin
      fwd_idx <= s2_idx;
      fwd_row <= row_new;
    end
  end

  // Stage two register and buffer occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      occupancy <= '0;
    end else begin
      if (s2_free) begin
        s2_valid <= q_valid;
      end
      if (commit) begin
        occupancy <= occupancy_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s2_cmd <= q_cmd;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (commit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res.status              <= status;
      res.accepted            <= accepted;
      res.queue_length        <= occ_next_ext[QLEN_W-1:0];
      res.received_count      <= report ? row_new.rx : '0;
      res.received_high_count <= report ? row_new.rx_high : '0;
      res.lost_count          <= report ? row_new.lost : '0;
      res.lost_high_count     <= report ? row_new.lost_high : '0;
      res.served_count        <= report ? row_new.served : '0;
    end
  end

endmodule

// File: hdl/atm_frame_discard_admission.sv
// Top level of the ATM frame discard admission block.
// Depends on afd_pkg, afd_in_if, afd_out_if, afd_front, afd_queue, afd_back.
//
// Usage: cell_in carries one transaction per cell arrival, cell departure or
// statistics query; result returns exactly one transaction for each, in
// order, with the admission decision, the buffer occupancy after the
// transaction and the five counters of the addressed channel.
// The thresholds are written through cfg_write, cfg_index and cfg_data while
// the block is idle; a write to an index outside the register map is ignored.
// An accepted input transaction is registered in the front stage, then in
// the command queue, the stage two register and the result register.
// Throughput: one transaction per cycle when nothing stalls, kept up by
// forwarding the previous write into the per-channel read-modify-write.
// Reset (synchronous, active high) clears occupancy, marks every channel as
// at the start of a frame with zero counters, restores the thresholds to 600
// and 100 and empties all stages; no clearing pass is needed.
// When the receiver stalls, the result register holds, the back stage waits
// and the command queue and front stage keep taking input until they fill,
// after which cell_in.ready drops.
`timescale 1ns / 1ps

module atm_frame_discard_admission
  import afd_pkg::*;
#(
  parameter int unsigned BUFFER_CELLS = BUFFER_CELLS_DEF,
  parameter int unsigned CHANNELS     = CHANNELS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  afd_in_if.sink                 cell_in,
  afd_out_if.source              result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t cfg;
  logic front_valid;
  cmd_t front_cmd;
  logic queue_space;
  logic queue_valid;
  cmd_t queue_cmd;
  logic queue_pop;

  // Threshold registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.early_discard_threshold <= EDT_RESET;
      cfg.low_priority_threshold  <= LPT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_EARLY_DISCARD: cfg.early_discard_threshold <= THR_W'(cfg_data);
        REG_LOW_PRIORITY:  cfg.low_priority_threshold  <= THR_W'(cfg_data);
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  afd_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (cell_in),
    .push_valid (front_valid),
    .push_cmd   (front_cmd),
    .push_ready (queue_space)
  );

  afd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_cmd   (front_cmd),
    .push_ready (queue_space),
    .pop_valid  (queue_valid),
    .pop_cmd    (queue_cmd),
    .pop        (queue_pop)
  );

  afd_back #(
    .BUFFER_CELLS (BUFFER_CELLS),
    .CHANNELS     (CHANNELS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (queue_valid),
    .q_cmd   (queue_cmd),
    .q_pop   (queue_pop),
    .res     (result)
  );

  // Reset empties the result register.
  a_reset_empties: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid after reset");

  // An accepted input transaction is held in the front stage next cycle.
  a_front_loaded: assert property (@(posedge clk) disable iff (rst)
    cell_in.valid && cell_in.ready |=> front_valid)
    else $error("accepted transaction missing from front stage");

  // The front stage keeps its command while the queue is full.
  a_front_holds: assert property (@(posedge clk) disable iff (rst)
    front_valid && !queue_space |=> front_valid && $stable(front_cmd))
    else $error("front stage lost a command while the queue was full");

endmodule

// File: tb/tb_atm_frame_discard_admission.sv
// Self-checking testbench for atm_frame_discard_admission: directed cells, then
// random traffic phases under several threshold settings, checked by a predictor.
// Depends on afd_pkg, afd_in_if, afd_out_if and the block itself.
`timescale 1ns / 1ps

module tb_atm_frame_discard_admission;
  import afd_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned HOT_COUNT    = 6;

  // Register index that is outside the register map; writes to it are dropped.
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = CFG_INDEX_W'(3);

  typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC} sink_mode_t;

  typedef struct packed {
    op_t               op;
    logic [CHAN_W-1:0] ch;
    logic              clp;
    logic              eof;
    logic              red;
  } cell_t;

  typedef struct packed {
    logic              status;
    logic              accepted;
    logic [QLEN_W-1:0] qlen;
    logic [CNT_W-1:0]  rx;
    logic [CNT_W-1:0]  rx_high;
    logic [CNT_W-1:0]  lost;
    logic [CNT_W-1:0]  lost_high;
    logic [CNT_W-1:0]  served;
  } outcome_t;

  // One line of the directed stimulus; typed marks a result written in by hand.
  typedef struct packed {
    cell_t    stim;
    logic     typed;
    outcome_t want;
  } vector_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  afd_in_if  cell_if ();
  afd_out_if res_if ();

  atm_frame_discard_admission u_top (
    .clk       (clk),
    .rst       (rst),
    .cell_in   (cell_if),
    .result    (res_if),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state: buffer occupancy, per-channel frame flags and counters.
  int unsigned      occ_model = 0;
  logic [THR_W-1:0] early_thr = EDT_RESET;
  logic [THR_W-1:0] low_thr   = LPT_RESET;
  bit               frame_open [CHANNELS_DEF] = '{default: 1'b1};
  bit               frame_take [CHANNELS_DEF] = '{default: 1'b0};
  logic [CNT_W-1:0] rx_cnt [CHANNELS_DEF]        = '{default: '0};
  logic [CNT_W-1:0] rx_high_cnt [CHANNELS_DEF]   = '{default: '0};
  logic [CNT_W-1:0] lost_cnt [CHANNELS_DEF]      = '{default: '0};
  logic [CNT_W-1:0] lost_high_cnt [CHANNELS_DEF] = '{default: '0};
  logic [CNT_W-1:0] served_cnt [CHANNELS_DEF]    = '{default: '0};

  outcome_t          pending_results [$];
  vector_t           vectors [$];
  logic [CHAN_W-1:0] hot_channels [HOT_COUNT];
  int unsigned       mismatches  = 0;
  int unsigned       cycle_count = 0;
  int unsigned       burst_left  = 0;
  sink_mode_t        sink_mode   = SINK_OPEN;
  int unsigned       sink_left   = 0;
  int unsigned       sink_tick   = 0;

  // Admission decision and counter update for one accepted transaction.
  function automatic outcome_t admit_cell(cell_t c);
    outcome_t    o;
    int unsigned ch;
    o  = '0;
    ch = c.ch;
    case (c.op)
      OP_AAL5, OP_STATS: begin
        if (ch >= CHANNELS_DEF) begin
          o.status = 1'b1;
        end else begin
          if (c.op == OP_AAL5) begin
            rx_cnt[ch] += 1;
            if (!c.clp) rx_high_cnt[ch] += 1;
            // The first cell of a frame decides whether the frame is taken.
            if (frame_open[ch]) begin
              frame_open[ch] = 1'b0;
              frame_take[ch] = (occ_model < early_thr) && !c.red;
            end
            if (c.eof) frame_open[ch] = 1'b1;
            // A low priority cell over the threshold drops the rest of its frame.
            if (c.clp && occ_model > low_thr) frame_take[ch] = 1'b0;
            if (frame_take[ch] && occ_model < BUFFER_CELLS_DEF) begin
              occ_model      += 1;
              served_cnt[ch] += 1;
              o.accepted      = 1'b1;
            end else begin
              if (frame_take[ch]) frame_take[ch] = 1'b0;
              lost_cnt[ch] += 1;
              if (!c.clp) lost_high_cnt[ch] += 1;
            end
          end
          o.rx        = rx_cnt[ch];
          o.rx_high   = rx_high_cnt[ch];
          o.lost      = lost_cnt[ch];
          o.lost_high = lost_high_cnt[ch];
          o.served    = served_cnt[ch];
        end
      end
      OP_OTHER: begin
        if (occ_model < BUFFER_CELLS_DEF) begin
          occ_model += 1;
          o.accepted = 1'b1;
        end
      end
      OP_DEPART: begin
        if (occ_model > 0) occ_model -= 1;
      end
    endcase
    o.qlen = occ_model[QLEN_W-1:0];
    return o;
  endfunction

  function automatic outcome_t outcome(logic acc, int unsigned ql, logic [CNT_W-1:0] rx,
                                       logic [CNT_W-1:0] rxh, logic [CNT_W-1:0] lost,
                                       logic [CNT_W-1:0] lh, logic [CNT_W-1:0] srv);
    return '{1'b0, acc, QLEN_W'(ql), rx, rxh, lost, lh, srv};
  endfunction

  function automatic vector_t row(op_t op, logic [CHAN_W-1:0] ch, logic clp, logic eof,
                                  logic red, logic typed, outcome_t want);
    return '{'{op, ch, clp, eof, red}, typed, want};
  endfunction

  // Clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Cycle budget for the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // The result side stalls on a pattern whose mode, open, random or periodic, changes at random.
  always @(negedge clk) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 2));
      sink_left = $urandom_range(16, 160);
    end
    sink_left--;
    sink_tick++;
    case (sink_mode)
      SINK_OPEN:   res_if.ready <= 1'b1;
      SINK_RANDOM: res_if.ready <= ($urandom_range(0, 3) != 0);
      default:     res_if.ready <= ((sink_tick % 5) < 3);
    endcase
  end

  // Compare every result transaction with the oldest prediction.
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      got = '{res_if.status, res_if.accepted, res_if.queue_length, res_if.received_count,
              res_if.received_high_count, res_if.lost_count, res_if.lost_high_count,
              res_if.served_count};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with nothing outstanding: %p", $realtime, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: result mismatch", $realtime);
            $display("  expected st=%0d acc=%0d ql=%0d rx=%0d rxh=%0d lost=%0d lh=%0d srv=%0d",
                     want.status, want.accepted, want.qlen, want.rx, want.rx_high,
                     want.lost, want.lost_high, want.served);
            $display("  actual   st=%0d acc=%0d ql=%0d rx=%0d rxh=%0d lost=%0d lh=%0d srv=%0d",
                     got.status, got.accepted, got.qlen, got.rx, got.rx_high,
                     got.lost, got.lost_high, got.served);
          end
        end
      end
    end
  end

  // Offer one transaction, in bursts separated by random gaps, and record its result.
  task automatic send_cell(cell_t c, logic typed, outcome_t want);
    outcome_t predicted;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      @(negedge clk);
      cell_if.valid <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
    end
    burst_left--;
    @(negedge clk);
    cell_if.valid              <= 1'b1;
    cell_if.operation          <= c.op;
    cell_if.channel            <= c.ch;
    cell_if.cell_loss_priority <= c.clp;
    cell_if.end_of_frame       <= c.eof;
    cell_if.red_early_drop     <= c.red;
    do @(posedge clk); while (!cell_if.ready);
    predicted = admit_cell(c);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic end_burst();
    @(negedge clk);
    cell_if.valid <= 1'b0;
    burst_left = 0;
  endtask

  // Wait for every outstanding result, then let the pipeline empty.
  task automatic settle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_EARLY_DISCARD) early_thr = val;
    else if (idx == REG_LOW_PRIORITY) low_thr = val;
  endtask

  // One traffic phase: set both thresholds, then stream frames on a few busy
  // channels mixed with stray cells, departures and statistics queries.
  task automatic run_phase(logic [CFG_DATA_W-1:0] edt, logic [CFG_DATA_W-1:0] lpt,
                           int unsigned count, int unsigned pct_aal5,
                           int unsigned pct_other, int unsigned pct_depart);
    cell_t       c;
    int unsigned pick;
    settle();
    write_reg(REG_EARLY_DISCARD, edt);
    write_reg(REG_LOW_PRIORITY, lpt);
    foreach (hot_channels[k]) hot_channels[k] = CHAN_W'($urandom_range(0, CHAN_SPAN - 1));
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < pct_aal5) c.op = OP_AAL5;
      else if (pick < pct_aal5 + pct_other) c.op = OP_OTHER;
      else if (pick < pct_aal5 + pct_other + pct_depart) c.op = OP_DEPART;
      else c.op = OP_STATS;
      c.ch  = ($urandom_range(0, 3) != 0) ? hot_channels[$urandom_range(0, HOT_COUNT - 1)]
                                          : CHAN_W'($urandom_range(0, CHAN_SPAN - 1));
      c.clp = ($urandom_range(0, 9) < 3);
      c.eof = ($urandom_range(0, 4) == 0);
      c.red = ($urandom_range(0, 9) == 0);
      send_cell(c, 1'b0, '0);
    end
    end_burst();
  endtask

  // Main sequence.
  initial begin
    rst                        = 1'b1;
    cfg_write                  = 1'b0;
    cfg_index                  = '0;
    cfg_data                   = '0;
    cell_if.valid              = 1'b0;
    cell_if.operation          = OP_STATS;
    cell_if.channel            = '0;
    cell_if.cell_loss_priority = 1'b0;
    cell_if.end_of_frame       = 1'b0;
    cell_if.red_early_drop     = 1'b0;
    res_if.ready               = 1'b0;

    // Directed cells at the reset thresholds of 600 and 100.
    vectors.push_back(row(OP_STATS,  8'h00, 0, 0, 0, 1, outcome(0, 0, 0, 0, 0, 0, 0)));
    vectors.push_back(row(OP_STATS,  8'hFF, 1, 1, 1, 1, outcome(0, 0, 0, 0, 0, 0, 0)));
    // Departure from an empty buffer keeps occupancy at zero.
    vectors.push_back(row(OP_DEPART, 8'h55, 1, 1, 1, 1, outcome(0, 0, 0, 0, 0, 0, 0)));
    // Other cells ignore the channel and report no counters.
    vectors.push_back(row(OP_OTHER,  8'hC8, 1, 1, 1, 1, outcome(1, 1, 0, 0, 0, 0, 0)));
    vectors.push_back(row(OP_AAL5,   8'h00, 0, 0, 0, 1, outcome(1, 2, 1, 1, 0, 0, 1)));
    // Mid-frame cells ignore the drop decision.
    vectors.push_back(row(OP_AAL5,   8'h00, 1, 1, 1, 1, outcome(1, 3, 2, 1, 0, 0, 2)));
    // A drop decision on the first cell refuses the whole frame.
    vectors.push_back(row(OP_AAL5,   8'hFF, 0, 1, 1, 1, outcome(0, 3, 1, 1, 1, 1, 0)));
    vectors.push_back(row(OP_AAL5,   8'hFF, 1, 0, 0, 1, outcome(1, 4, 2, 1, 1, 1, 1)));
    vectors.push_back(row(OP_AAL5,   8'hFF, 0, 0, 1, 1, outcome(1, 5, 3, 2, 1, 1, 2)));
    vectors.push_back(row(OP_STATS,  8'hFF, 1, 0, 1, 1, outcome(0, 5, 3, 2, 1, 1, 2)));
    vectors.push_back(row(OP_DEPART, 8'hFF, 0, 0, 0, 1, outcome(0, 4, 0, 0, 0, 0, 0)));
    vectors.push_back(row(OP_AAL5,   8'hAA, 1, 0, 0, 0, '0));
    vectors.push_back(row(OP_OTHER,  8'h00, 0, 0, 0, 0, '0));
    vectors.push_back(row(OP_AAL5,   8'hAA, 0, 1, 1, 0, '0));
    vectors.push_back(row(OP_STATS,  8'hAA, 0, 0, 0, 0, '0));
    vectors.push_back(row(OP_AAL5,   8'h01, 1, 1, 0, 0, '0));
    vectors.push_back(row(OP_DEPART, 8'h00, 0, 0, 0, 0, '0));
    vectors.push_back(row(OP_STATS,  8'h00, 0, 0, 0, 0, '0));
    vectors.push_back(row(OP_AAL5,   8'h80, 0, 0, 0, 0, '0));
    vectors.push_back(row(OP_AAL5,   8'h7F, 1, 1, 1, 0, '0));
    vectors.push_back(row(OP_STATS,  8'h7F, 0, 0, 0, 0, '0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (vectors[i]) send_cell(vectors[i].stim, vectors[i].typed, vectors[i].want);
    end_burst();

    // A write outside the register map must leave both thresholds alone.
    settle();
    write_reg(REG_UNMAPPED, '1);

    // Moderate thresholds with occupancy drifting upward.
    run_phase(11'd300, 11'd50, 50, 45, 25, 22);
    // Highest legal thresholds while the buffer fills to the top.
    run_phase(11'd1024, 11'd1024, 1080, 15, 85, 0);
    // Raw extremes: every new frame refused, low priority never discarded.
    run_phase(11'd0, 11'h7FF, 25, 40, 20, 30);
    // Non-red frames admitted, low priority cells over zero dropped; mostly draining.
    run_phase(11'h7FF, 11'd0, 35, 10, 3, 85);
    // Lowest legal thresholds.
    run_phase(11'd1, 11'd1, 25, 35, 10, 50);
    // Back to the reset values with balanced traffic.
    run_phase(EDT_RESET, LPT_RESET, 20, 40, 20, 30);

    settle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
